FILE: rtl/rpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Types and fixed constants shared by the ray/plane intersection core.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int WORD_W   = 32;  // coordinate word width
  localparam int AXES     = 3;   // x, y, z
  localparam int SUM_W    = 66;  // exact dot products, signed
  localparam int MAG_W    = 64;  // magnitude of a dot product
  localparam int PROD_W   = 96;  // direction magnitude times numerator
  localparam int QUOT_W   = 42;  // quotient bits produced by the divider
  localparam int CAP_BIT  = 40;  // quotient saturates at 2^CAP_BIT
  localparam int QC_W     = CAP_BIT + 1;
  localparam int PIPE_LAT = 49;  // start transfer to done strobe

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/ray_plane_intersect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersect_core
// Intersects each ray with the configured plane n.P = D and returns the
// saturated hit point, or -1.0 in every coordinate for a parallel ray.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle; busy is always low.
// Most of the latency comes from the restoring divider, one quotient bit per stage (42).
// Reset: synchronous rst clears all stage valid bits and the plane registers.
// Results are strobed for one cycle on done; the receiver cannot stall.
module ray_plane_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [rpi_pkg::WORD_W-1:0] origin_x,
  input  logic signed [rpi_pkg::WORD_W-1:0] origin_y,
  input  logic signed [rpi_pkg::WORD_W-1:0] origin_z,
  input  logic signed [rpi_pkg::WORD_W-1:0] dir_x,
  input  logic signed [rpi_pkg::WORD_W-1:0] dir_y,
  input  logic signed [rpi_pkg::WORD_W-1:0] dir_z,
  input  logic                           cfg_we,
  input  rpi_pkg::cfg_reg_t              cfg_index,
  input  logic [rpi_pkg::WORD_W-1:0]     cfg_wdata,
  output logic                           done,
  output logic                           hit,
  output logic signed [rpi_pkg::WORD_W-1:0] point_x,
  output logic signed [rpi_pkg::WORD_W-1:0] point_y,
  output logic signed [rpi_pkg::WORD_W-1:0] point_z
);
  import rpi_pkg::*;

  localparam logic signed [WORD_W-1:0] MISS_VAL = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [SUM_W:0]    SAT_MAX  = (SUM_W+1)'(64'sd2147483647);
  localparam logic signed [SUM_W:0]    SAT_MIN  = -(SUM_W+1)'(64'sd2147483648);

  assign busy = 1'b0;

  // plane registers
  logic signed [WORD_W-1:0] normal [0:AXES-1];
  logic signed [WORD_W-1:0] plane_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) normal[i] <= '0;
      plane_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X:     normal[0]    <= $signed(cfg_wdata);
        REG_NORMAL_Y:     normal[1]    <= $signed(cfg_wdata);
        REG_NORMAL_Z:     normal[2]    <= $signed(cfg_wdata);
        REG_PLANE_OFFSET: plane_offset <= $signed(cfg_wdata);
        default:          plane_offset <= plane_offset;
      endcase
    end
  end

  logic signed [WORD_W-1:0] in_o [0:AXES-1];
  logic signed [WORD_W-1:0] in_d [0:AXES-1];
  assign in_o[0] = origin_x;
  assign in_o[1] = origin_y;
  assign in_o[2] = origin_z;
  assign in_d[0] = dir_x;
  assign in_d[1] = dir_y;
  assign in_d[2] = dir_z;

  // stage 1: n*d and n*o products
  logic                       s1_valid;
  logic signed [2*WORD_W-1:0] s1_nd [0:AXES-1];
  logic signed [2*WORD_W-1:0] s1_no [0:AXES-1];
  logic signed [WORD_W-1:0]   s1_o  [0:AXES-1];
  logic signed [WORD_W-1:0]   s1_d  [0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start;
    for (int i = 0; i < AXES; i++) begin
      s1_nd[i] <= normal[i] * in_d[i];
      s1_no[i] <= normal[i] * in_o[i];
      s1_o[i]  <= in_o[i];
      s1_d[i]  <= in_d[i];
    end
  end

  // stage 2: exact dot products
  logic                     s2_valid;
  logic signed [SUM_W-1:0]  s2_den;
  logic signed [SUM_W-1:0]  s2_num;
  logic signed [WORD_W-1:0] s2_o [0:AXES-1];
  logic signed [WORD_W-1:0] s2_d [0:AXES-1];
  logic signed [SUM_W-1:0]  off_ext;

  assign off_ext = $signed({{(SUM_W-WORD_W){plane_offset[WORD_W-1]}}, plane_offset})
                   <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_den <= SUM_W'(s1_nd[0]) + SUM_W'(s1_nd[1]) + SUM_W'(s1_nd[2]);
    s2_num <= off_ext - SUM_W'(s1_no[0]) - SUM_W'(s1_no[1]) - SUM_W'(s1_no[2]);
    for (int i = 0; i < AXES; i++) begin
      s2_o[i] <= s1_o[i];
      s2_d[i] <= s1_d[i];
    end
  end

  // stage 3: magnitudes and result signs
  logic                     s3_valid;
  logic                     s3_hit;
  logic [MAG_W-1:0]         s3_den_m;
  logic [MAG_W-1:0]         s3_num_m;
  logic [WORD_W-1:0]        s3_dm  [0:AXES-1];
  logic                     s3_neg [0:AXES-1];
  logic signed [WORD_W-1:0] s3_o   [0:AXES-1];
  logic                     den_neg, num_neg;

  assign den_neg = s2_den[SUM_W-1];
  assign num_neg = s2_num[SUM_W-1];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_hit   <= (s2_den != '0);
    s3_den_m <= den_neg ? MAG_W'(-s2_den) : MAG_W'(s2_den);
    s3_num_m <= num_neg ? MAG_W'(-s2_num) : MAG_W'(s2_num);
    for (int i = 0; i < AXES; i++) begin
      s3_dm[i]  <= s2_d[i][WORD_W-1] ? WORD_W'(-s2_d[i]) : WORD_W'(s2_d[i]);
      s3_neg[i] <= s2_d[i][WORD_W-1] ^ num_neg ^ den_neg;
      s3_o[i]   <= s2_o[i];
    end
  end

  // stage 4: |d| * |num| as two 32x32 partial products
  logic                     s4_valid;
  logic                     s4_hit;
  logic [MAG_W-1:0]         s4_den_m;
  logic [2*WORD_W-1:0]      s4_pl  [0:AXES-1];
  logic [2*WORD_W-1:0]      s4_ph  [0:AXES-1];
  logic                     s4_neg [0:AXES-1];
  logic signed [WORD_W-1:0] s4_o   [0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
    s4_hit   <= s3_hit;
    s4_den_m <= s3_den_m;
    for (int i = 0; i < AXES; i++) begin
      s4_pl[i]  <= s3_dm[i] * s3_num_m[WORD_W-1:0];
      s4_ph[i]  <= s3_dm[i] * s3_num_m[MAG_W-1:WORD_W];
      s4_neg[i] <= s3_neg[i];
      s4_o[i]   <= s3_o[i];
    end
  end

  // stage 5: combine partial products into the dividend
  logic                     s5_valid;
  logic                     s5_hit;
  logic [MAG_W-1:0]         s5_den_m;
  logic [PROD_W-1:0]        s5_p   [0:AXES-1];
  logic                     s5_neg [0:AXES-1];
  logic signed [WORD_W-1:0] s5_o   [0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else     s5_valid <= s4_valid;
    s5_hit   <= s4_hit;
    s5_den_m <= s4_den_m;
    for (int i = 0; i < AXES; i++) begin
      s5_p[i]   <= PROD_W'(s4_pl[i]) + {s4_ph[i], {WORD_W{1'b0}}};
      s5_neg[i] <= s4_neg[i];
      s5_o[i]   <= s4_o[i];
    end
  end

  // divider: stage 0 checks quotient overflow, stages 1..QUOT_W make one bit each
  logic                     dv_valid [0:QUOT_W];
  logic                     dv_hit   [0:QUOT_W];
  logic [MAG_W-1:0]         dv_den   [0:QUOT_W];
  logic [MAG_W-1:0]         dv_rem   [0:QUOT_W][0:AXES-1];
  logic [QUOT_W-1:0]        dv_low   [0:QUOT_W][0:AXES-1];
  logic [QUOT_W-1:0]        dv_q     [0:QUOT_W][0:AXES-1];
  logic                     dv_ovf   [0:QUOT_W][0:AXES-1];
  logic                     dv_neg   [0:QUOT_W][0:AXES-1];
  logic signed [WORD_W-1:0] dv_o     [0:QUOT_W][0:AXES-1];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else     dv_valid[0] <= s5_valid;
    dv_hit[0] <= s5_hit;
    dv_den[0] <= s5_den_m;
    for (int i = 0; i < AXES; i++) begin
      dv_rem[0][i] <= MAG_W'(s5_p[i][PROD_W-1:QUOT_W]);
      dv_ovf[0][i] <= (MAG_W'(s5_p[i][PROD_W-1:QUOT_W]) >= s5_den_m);
      dv_low[0][i] <= s5_p[i][QUOT_W-1:0];
      dv_q[0][i]   <= '0;
      dv_neg[0][i] <= s5_neg[i];
      dv_o[0][i]   <= s5_o[i];
    end
  end

  for (genvar k = 1; k <= QUOT_W; k++) begin : g_div
    logic [MAG_W:0] trial [0:AXES-1];
    logic           ge    [0:AXES-1];

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        trial[i] = {dv_rem[k-1][i], dv_low[k-1][i][QUOT_W-1]};
        ge[i]    = (trial[i] >= {1'b0, dv_den[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_valid[k] <= 1'b0;
      else     dv_valid[k] <= dv_valid[k-1];
      dv_hit[k] <= dv_hit[k-1];
      dv_den[k] <= dv_den[k-1];
      for (int i = 0; i < AXES; i++) begin
        dv_rem[k][i] <= ge[i] ? MAG_W'(trial[i] - {1'b0, dv_den[k-1]}) : MAG_W'(trial[i]);
        dv_low[k][i] <= {dv_low[k-1][i][QUOT_W-2:0], 1'b0};
        dv_q[k][i]   <= {dv_q[k-1][i][QUOT_W-2:0], ge[i]};
        dv_ovf[k][i] <= dv_ovf[k-1][i];
        dv_neg[k][i] <= dv_neg[k-1][i];
        dv_o[k][i]   <= dv_o[k-1][i];
      end
    end
  end

  // final stage: cap quotient, apply sign, add origin, saturate; MISS_VAL on a miss
  logic [QC_W-1:0]          fin_qc  [0:AXES-1];
  logic signed [SUM_W:0]    fin_sum [0:AXES-1];
  logic signed [WORD_W-1:0] fin_pt  [0:AXES-1];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (dv_ovf[QUOT_W][i] || (dv_q[QUOT_W][i] > QUOT_W'(1) << CAP_BIT))
        fin_qc[i] = QC_W'(1) << CAP_BIT;
      else
        fin_qc[i] = dv_q[QUOT_W][i][QC_W-1:0];
      fin_sum[i] = $signed({{(SUM_W+1-WORD_W){dv_o[QUOT_W][i][WORD_W-1]}}, dv_o[QUOT_W][i]})
                   + (dv_neg[QUOT_W][i] ? -$signed((SUM_W+1)'(fin_qc[i]))
                                        :  $signed((SUM_W+1)'(fin_qc[i])));
      if (!dv_hit[QUOT_W])       fin_pt[i] = MISS_VAL;
      else if (fin_sum[i] > SAT_MAX) fin_pt[i] = 32'sh7FFF_FFFF;
      else if (fin_sum[i] < SAT_MIN) fin_pt[i] = 32'sh8000_0000;
      else                       fin_pt[i] = WORD_W'(fin_sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_valid[QUOT_W];
    hit     <= dv_hit[QUOT_W];
    point_x <= fin_pt[0];
    point_y <= fin_pt[1];
    point_z <= fin_pt[2];
  end

  // every accepted ray produces its done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("result strobe missing after start transfer");

  // a miss always carries -1.0 in every coordinate
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (point_x == MISS_VAL && point_y == MISS_VAL && point_z == MISS_VAL))
    else $error("miss result with wrong point");

  // hit flag matches a nonzero denominator magnitude
  a_hit_den: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_hit == (s3_den_m != '0)))
    else $error("hit flag disagrees with denominator");

  // restoring divider keeps its remainder below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[QUOT_W] && dv_hit[QUOT_W] && !dv_ovf[QUOT_W][0])
      |-> (dv_rem[QUOT_W][0] < dv_den[QUOT_W]))
    else $error("divider remainder out of range");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks ray_plane_intersect_core against a bit-exact predictor of the hit
// point. A short table of directed rays (parallel rays, unit planes, extreme
// words) runs first, then random rays under several plane settings. Every
// accepted ray gets its prediction or typed expectation at its start transfer and
// is compared field by field with the next done strobe.
// ----------------------------------------------------------------------------
module testbench;
  import rpi_pkg::*;

  localparam int FRAC       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_RAYS  = 540;
  localparam int PHASES     = 6;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic  hit;
    word_t px, py, pz;
  } hit_point_t;

  // directed row: plane selector, ray, and an optional typed expectation
  typedef struct packed {
    logic [1:0] plane_sel;
    ray_t       ray;
    logic       typed;
    hit_point_t want;
  } row_t;

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t MONE = -32'sh0001_0000;
  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  logic clk, rst, start, busy, cfg_we, done, hit;
  cfg_reg_t cfg_index;
  logic [WORD_W-1:0] cfg_wdata;
  word_t origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  word_t point_x, point_y, point_z;

  // driven alongside the ray: typed expectation for directed rows
  logic       drv_typed;
  hit_point_t drv_want;

  word_t plane[4];            // mirror of normal x/y/z and offset
  hit_point_t pending_hits[$];
  int errors, cycles;

  ray_plane_intersect_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .done(done), .hit(hit),
    .point_x(point_x), .point_y(point_y), .point_z(point_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact intersection: o + d*(D*2^F - n.o)/(n.d), quotient capped, saturated; -1.0 on a miss
  function automatic hit_point_t predict_hit(ray_t r);
    logic signed [65:0] den, num;
    logic [63:0] den_m, num_m, dm;
    logic [127:0] quo;
    logic signed [65:0] sum;
    logic signed [63:0] qs;
    word_t o[3], d[3], res[3];
    hit_point_t hp;
    o = '{r.ox, r.oy, r.oz};
    d = '{r.dx, r.dy, r.dz};
    den = '0;
    num = 66'(plane[REG_PLANE_OFFSET]) <<< FRAC;
    for (int i = 0; i < 3; i++) begin
      den += 66'(plane[i]) * 66'(d[i]);
      num -= 66'(plane[i]) * 66'(o[i]);
    end
    if (den == 0) begin
      hp.hit = 1'b0;
      hp.px = MONE;
      hp.py = MONE;
      hp.pz = MONE;
      return hp;
    end
    den_m = den[65] ? 64'(-den) : 64'(den);
    num_m = num[65] ? 64'(-num) : 64'(num);
    for (int i = 0; i < 3; i++) begin
      dm = d[i][31] ? 64'(-64'(d[i])) : 64'(d[i]);
      quo = (128'(dm) * 128'(num_m)) / 128'(den_m);
      if (quo > (128'd1 << CAP_BIT)) quo = 128'd1 << CAP_BIT;
      qs = (d[i][31] ^ num[65] ^ den[65]) ? -64'(quo) : 64'(quo);
      sum = 66'(o[i]) + 66'(qs);
      if (sum > 66'(WMAX)) res[i] = WMAX;
      else if (sum < 66'(WMIN)) res[i] = WMIN;
      else res[i] = word_t'(sum);
    end
    hp.hit = 1'b1;
    hp.px = res[0];
    hp.py = res[1];
    hp.pz = res[2];
    return hp;
  endfunction

  // monitor: predict on each start transfer, check each done strobe
  always @(posedge clk) begin
    hit_point_t want, got;
    if (rst) begin
      plane <= '{default: '0};
    end else begin
      if (cfg_we) plane[cfg_index] <= cfg_wdata;
      if (start && !busy) begin
        if (drv_typed) pending_hits.push_back(drv_want);
        else pending_hits.push_back(predict_hit({origin_x, origin_y, origin_z,
                                                 dir_x, dir_y, dir_z}));
      end
      if (done) begin
        got = '{hit, point_x, point_y, point_z};
        if (pending_hits.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_hits.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: hit %b/%b x %h/%h y %h/%h z %h/%h (exp/act)",
                       want.hit, got.hit, want.px, got.px, want.py, got.py,
                       want.pz, got.pz);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // one ray transfer; start stays high across back-to-back rays
  task automatic send_ray(ray_t r, logic typed, hit_point_t want, bit no_gap);
    int gap;
    logic b;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= r;
    drv_typed <= typed;
    drv_want  <= want;
    start     <= 1'b1;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
  endtask

  // wait for the pipeline to empty, then write all four plane registers
  task automatic set_plane(word_t nx, word_t ny, word_t nz, word_t off);
    word_t v[4];
    v = '{nx, ny, nz, off};
    start <= 1'b0;
    @(posedge clk);
    wait (pending_hits.size() == 0);
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t small_word();
    return word_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  function automatic word_t pick_word(int kind);
    case (kind)
      0: return small_word();
      1: return word_t'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0: return WMAX;
          1: return WMIN;
          2: return '0;
          3: return MONE;
          default: return word_t'($urandom());
        endcase
      end
    endcase
  endfunction

  row_t table_rows[$];
  word_t plane_sets[3][4];

  initial begin
    ray_t r;
    int kind, sel, cur;
    bit no_idle;
    errors = 0;
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NORMAL_X;
    cfg_wdata = '0;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
    drv_typed = 1'b0;
    drv_want = '0;

    plane_sets[0] = '{'0, '0, '0, '0};
    plane_sets[1] = '{ONE, '0, '0, 32'sh0002_0000};
    plane_sets[2] = '{WMAX, WMIN, WMAX, WMIN};

    // after reset: zero normal, every ray is parallel
    table_rows.push_back('{0, '{ONE, 2*ONE, 3*ONE, ONE, ONE, ONE}, 1,
                           '{1'b0, MONE, MONE, MONE}});
    table_rows.push_back('{0, '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN}, 1,
                           '{1'b0, MONE, MONE, MONE}});
    // plane x = 2.0
    table_rows.push_back('{1, '{'0, '0, '0, ONE, '0, '0}, 1,
                           '{1'b1, 2*ONE, '0, '0}});
    table_rows.push_back('{1, '{5*ONE, ONE, '0, MONE, '0, '0}, 1,
                           '{1'b1, 2*ONE, ONE, '0}});
    table_rows.push_back('{1, '{'0, '0, '0, '0, ONE, '0}, 1,
                           '{1'b0, MONE, MONE, MONE}});
    // hit behind the origin
    table_rows.push_back('{1, '{3*ONE, '0, '0, ONE, '0, '0}, 1,
                           '{1'b1, 2*ONE, '0, '0}});
    table_rows.push_back('{1, '{WMAX, WMIN, WMAX, ONE, WMAX, WMIN}, 0, '0});
    table_rows.push_back('{1, '{WMIN, WMAX, '0, 32'sh1, WMIN, WMAX}, 0, '0});
    table_rows.push_back('{1, '{'0, '0, '0, WMIN, 32'sh1, '1}, 0, '0});
    // extreme plane words
    table_rows.push_back('{2, '{WMAX, WMAX, WMAX, WMAX, WMAX, WMAX}, 0, '0});
    table_rows.push_back('{2, '{WMIN, WMIN, WMIN, WMIN, WMIN, WMIN}, 0, '0});
    table_rows.push_back('{2, '{'0, '0, '0, 32'sh1, '0, '0}, 0, '0});
    table_rows.push_back('{2, '{WMAX, WMIN, '0, 32'sh1, 32'sh1, '0}, 0, '0});
    table_rows.push_back('{2, '{'1, '1, '1, 32'sh1, 32'sh1, 32'sh1}, 0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    cur = 0;
    foreach (table_rows[i]) begin
      if (table_rows[i].plane_sel != cur) begin
        cur = table_rows[i].plane_sel;
        set_plane(plane_sets[cur][0], plane_sets[cur][1],
                  plane_sets[cur][2], plane_sets[cur][3]);
      end
      send_ray(table_rows[i].ray, table_rows[i].typed, table_rows[i].want, 0);
    end

    // random phases, each under its own plane
    for (int p = 0; p < PHASES; p++) begin
      sel = p % 3;
      if (sel == 0)
        set_plane(small_word(), small_word(), small_word(), small_word());
      else if (sel == 1)
        set_plane(pick_word(2), pick_word(2), pick_word(2), pick_word(2));
      else
        set_plane(word_t'($urandom()), word_t'($urandom()),
                  word_t'($urandom()), word_t'($urandom()));
      no_idle = (p == 2);
      for (int k = 0; k < RAND_RAYS / PHASES; k++) begin
        kind = $urandom_range(0, 19);
        if (kind < 11) begin
          r = '{small_word(), small_word(), small_word(),
                small_word(), small_word(), small_word()};
        end else if (kind < 14) begin
          r = '{word_t'($urandom()), word_t'($urandom()), word_t'($urandom()),
                word_t'($urandom()), word_t'($urandom()), word_t'($urandom())};
        end else if (kind < 16) begin
          // direction in the plane: n.d = 0
          r = '{pick_word(0), pick_word(1), pick_word(2),
                plane[REG_NORMAL_Y], -plane[REG_NORMAL_X], '0};
          if (plane[REG_NORMAL_Z] != 0 || plane[REG_NORMAL_X] == WMIN ||
              $urandom_range(0, 3) == 0)
            r.dx = '0;
          if (r.dx == '0) begin
            r.dy = '0;
            r.dz = '0;
          end
        end else begin
          r = '{pick_word(2), pick_word(2), pick_word(2),
                pick_word(2), pick_word(2), pick_word(2)};
        end
        send_ray(r, 1'b0, '0, no_idle);
      end
    end
    start <= 1'b0;

    // drain, then let the pipeline run out
    wait (pending_hits.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rpi_pkg.sv
rtl/ray_plane_intersect_core.sv
sim/testbench.sv
